>>> hw/rtl/pixel_point_operation_unit_core_defines.svh
// assertion macros for the pixel point operation unit
`ifndef PIXEL_POINT_OPERATION_UNIT_CORE_DEFINES_SVH
`define PIXEL_POINT_OPERATION_UNIT_CORE_DEFINES_SVH

// checked property, ignored while reset is asserted
`define PPOU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked property, also evaluated during reset
`define PPOU_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/ppou_pkg.sv
// shared types, constants and helper functions of the pixel point operation unit
`timescale 1ns / 1ps
`default_nettype none

package ppou_pkg;

    localparam int PIX_W    = 8;
    localparam int WEIGHT_W = 9;
    localparam int GAIN_W   = 12;
    localparam int OFFS_W   = 9;
    localparam int CFG_W    = 12;
    localparam int INDEX_W  = 3;
    // signed lane product: 13-bit gain operand times 9-bit pixel operand
    localparam int PROD_W   = 22;
    localparam int SAT_W    = 14;

    // mode codes
    localparam logic [3:0] MODE_COPY       = 4'd0;
    localparam logic [3:0] MODE_BLUE       = 4'd1;
    localparam logic [3:0] MODE_GREEN      = 4'd2;
    localparam logic [3:0] MODE_RED        = 4'd3;
    localparam logic [3:0] MODE_AVG_GRAY   = 4'd4;
    localparam logic [3:0] MODE_WGT_GRAY   = 4'd5;
    localparam logic [3:0] MODE_QUANTIZE   = 4'd6;
    localparam logic [3:0] MODE_BRIGHTNESS = 4'd7;
    localparam logic [3:0] MODE_CONTRAST   = 4'd8;
    localparam logic [3:0] MODE_NEGATIVE   = 4'd9;
    localparam logic [3:0] MODE_THRESHOLD  = 4'd10;

    // register indexes
    localparam logic [INDEX_W-1:0] REG_MODE        = 3'd0;
    localparam logic [INDEX_W-1:0] REG_RED_WEIGHT  = 3'd1;
    localparam logic [INDEX_W-1:0] REG_GREEN_WEIGHT = 3'd2;
    localparam logic [INDEX_W-1:0] REG_BLUE_WEIGHT = 3'd3;
    localparam logic [INDEX_W-1:0] REG_QUANT_LOG2  = 3'd4;
    localparam logic [INDEX_W-1:0] REG_BRIGHT_OFFS = 3'd5;
    localparam logic [INDEX_W-1:0] REG_CONTR_GAIN  = 3'd6;
    localparam logic [INDEX_W-1:0] REG_THRESHOLD   = 3'd7;

    // reciprocal of 3 in Q0.11, exact floor for sums up to 765
    localparam logic [9:0] RECIP3 = 10'd683;
    localparam logic [8:0] CONTRAST_MID = 9'd128;

    typedef struct packed {
        logic load;
        logic weighted;
    } lane_ctrl_t;

    // saturate a signed value to 0..255
    function automatic logic [PIX_W-1:0] sat_byte(input logic signed [SAT_W-1:0] v);
        logic [PIX_W-1:0] r;
        if (v < 0)
            r = '0;
        else if (v > $signed(SAT_W'(255)))
            r = '1;
        else
            r = v[PIX_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/pixel_point_operation_unit_core.sv
// top level of the pixel point operation unit: config registers, two-stage pixel pipeline
//
//  channel | direction | handshake             | payload
//  s_axis  | in        | tvalid / tready       | tdata: pix_blue, pix_green, pix_red
//  m_axis  | out       | tvalid / tready       | tdata: out_blue, out_green, out_red;
//          |           |                       | tuser: single_channel
//  cfg     | in        | we (no wait)          | index, data
//
//  one item per cycle sustained while m_axis_tready stays high; the accepting edge loads
//  stage one, and the result register takes the item once stage two can advance;
//  stage one holds the pixel, the average gray and the per-channel products,
//  stage two holds the finished result item
//  rst_n clears valid flags and loads the register reset values asynchronously
//  a stalled result holds stage two; stage one still fills, then ready drops
`timescale 1ns / 1ps
`default_nettype none

`include "pixel_point_operation_unit_core_defines.svh"

module pixel_point_operation_unit_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // input pixel items
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [23:0]                     s_axis_tdata,  // pix_blue, pix_green, pix_red
    // result items
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [23:0]                          m_axis_tdata,  // out_blue, out_green, out_red
    output logic                                 m_axis_tuser,  // single_channel
    // configuration writes
    input  wire logic                            cfg_we,
    input  wire logic [ppou_pkg::INDEX_W-1:0]    cfg_index,
    input  wire logic [ppou_pkg::CFG_W-1:0]      cfg_data
);
    import ppou_pkg::*;

    // configuration registers
    logic [3:0]          mode_reg;
    logic [WEIGHT_W-1:0] red_weight_reg;
    logic [WEIGHT_W-1:0] green_weight_reg;
    logic [WEIGHT_W-1:0] blue_weight_reg;
    logic [2:0]          quant_log2_reg;
    logic [OFFS_W-1:0]   bright_offs_reg;
    logic [GAIN_W-1:0]   contr_gain_reg;
    logic [PIX_W-1:0]    threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_COPY;
            red_weight_reg   <= 9'd77;
            green_weight_reg <= 9'd150;
            blue_weight_reg  <= 9'd29;
            quant_log2_reg   <= 3'd4;
            bright_offs_reg  <= 9'd33;
            contr_gain_reg   <= 12'd128;
            threshold_reg    <= 8'd100;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE:         mode_reg         <= cfg_data[3:0];
                REG_RED_WEIGHT:   red_weight_reg   <= cfg_data[WEIGHT_W-1:0];
                REG_GREEN_WEIGHT: green_weight_reg <= cfg_data[WEIGHT_W-1:0];
                REG_BLUE_WEIGHT:  blue_weight_reg  <= cfg_data[WEIGHT_W-1:0];
                REG_QUANT_LOG2:   quant_log2_reg   <= cfg_data[2:0];
                REG_BRIGHT_OFFS:  bright_offs_reg  <= cfg_data[OFFS_W-1:0];
                REG_CONTR_GAIN:   contr_gain_reg   <= cfg_data[GAIN_W-1:0];
                REG_THRESHOLD:    threshold_reg    <= cfg_data[PIX_W-1:0];
                default:          ;
            endcase
        end
    end

    // pipeline handshake
    logic in_valid_reg;
    logic out_valid_reg;
    logic out_advance;
    logic in_load;

    assign out_advance   = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || out_advance;
    assign in_load       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_load)
                in_valid_reg <= 1'b1;
            else if (out_advance)
                in_valid_reg <= 1'b0;
            if (out_advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    // stage one: per-channel lanes and the average gray
    lane_ctrl_t                lane_ctrl;
    logic [PIX_W-1:0]          blue_reg, green_reg, red_reg;
    logic signed [PROD_W-1:0]  blue_prod_reg, green_prod_reg, red_prod_reg;

    assign lane_ctrl.load     = in_load;
    assign lane_ctrl.weighted = (mode_reg == MODE_WGT_GRAY);

    ppou_lane u_lane_blue (
        .clk      (clk),
        .ctrl     (lane_ctrl),
        .pix      (s_axis_tdata[7:0]),
        .weight   (blue_weight_reg),
        .gain     (contr_gain_reg),
        .pix_reg  (blue_reg),
        .prod_reg (blue_prod_reg)
    );

    ppou_lane u_lane_green (
        .clk      (clk),
        .ctrl     (lane_ctrl),
        .pix      (s_axis_tdata[15:8]),
        .weight   (green_weight_reg),
        .gain     (contr_gain_reg),
        .pix_reg  (green_reg),
        .prod_reg (green_prod_reg)
    );

    ppou_lane u_lane_red (
        .clk      (clk),
        .ctrl     (lane_ctrl),
        .pix      (s_axis_tdata[23:16]),
        .weight   (red_weight_reg),
        .gain     (contr_gain_reg),
        .pix_reg  (red_reg),
        .prod_reg (red_prod_reg)
    );

    // (r + g + b) / 3 by reciprocal multiply
    logic [9:0]       pix_sum;
    logic [19:0]      avg_scaled;
    logic [PIX_W-1:0] avg_reg;

    assign pix_sum    = 10'(s_axis_tdata[7:0]) + 10'(s_axis_tdata[15:8])
                      + 10'(s_axis_tdata[23:16]);
    assign avg_scaled = 20'(pix_sum) * 20'(RECIP3);

    always_ff @(posedge clk)
    begin
        if (in_load)
            avg_reg <= avg_scaled[18:11];
    end

    // stage two: mode select, sums and clamps
    logic signed [PROD_W+1:0] wsum;
    logic [PIX_W-1:0]         wgray;
    logic [2:0]               quant_n;
    logic [11:0]              quant_full;
    logic signed [SAT_W-1:0]  offs_ext;

    logic [PIX_W-1:0] ob_next, og_next, or_next;
    logic             single_next;

    // contrast: floor(prod / 256) + 128, clamped
    function automatic logic [PIX_W-1:0] contrast_chan(input logic signed [PROD_W-1:0] p);
        logic signed [SAT_W-1:0] q;
        q = SAT_W'(p >>> 8) + $signed(SAT_W'(128));
        return sat_byte(q);
    endfunction

    always_comb
    begin
        wsum = (PROD_W+2)'(blue_prod_reg) + (PROD_W+2)'(green_prod_reg)
             + (PROD_W+2)'(red_prod_reg);
        // weighted sums beyond the 8-bit range saturate
        if (|wsum[PROD_W+1:16])
            wgray = '1;
        else
            wgray = wsum[15:8];

        // out-of-range level counts fold to the nearest legal one
        if (quant_log2_reg == 3'd0)
            quant_n = 3'd1;
        else if (quant_log2_reg > 3'd4)
            quant_n = 3'd4;
        else
            quant_n = quant_log2_reg;
        case (quant_n)
            3'd1:    quant_full = 12'(avg_reg[7])   * 12'd255;
            3'd2:    quant_full = 12'(avg_reg[7:6]) * 12'd85;
            3'd3:    quant_full = 12'(avg_reg[7:5]) * 12'd36;
            default: quant_full = 12'(avg_reg[7:4]) * 12'd17;
        endcase

        offs_ext = SAT_W'($signed(bright_offs_reg));

        ob_next     = blue_reg;
        og_next     = green_reg;
        or_next     = red_reg;
        single_next = 1'b0;
        case (mode_reg)
            MODE_BLUE:
            begin
                og_next = '0;
                or_next = '0;
            end
            MODE_GREEN:
            begin
                ob_next = '0;
                or_next = '0;
            end
            MODE_RED:
            begin
                ob_next = '0;
                og_next = '0;
            end
            MODE_AVG_GRAY:
            begin
                ob_next     = avg_reg;
                single_next = 1'b1;
            end
            MODE_WGT_GRAY:
            begin
                ob_next     = wgray;
                single_next = 1'b1;
            end
            MODE_QUANTIZE:
            begin
                ob_next     = quant_full[PIX_W-1:0];
                single_next = 1'b1;
            end
            MODE_BRIGHTNESS:
            begin
                ob_next = sat_byte($signed(SAT_W'(blue_reg)) + offs_ext);
                og_next = sat_byte($signed(SAT_W'(green_reg)) + offs_ext);
                or_next = sat_byte($signed(SAT_W'(red_reg)) + offs_ext);
            end
            MODE_CONTRAST:
            begin
                ob_next = contrast_chan(blue_prod_reg);
                og_next = contrast_chan(green_prod_reg);
                or_next = contrast_chan(red_prod_reg);
            end
            MODE_NEGATIVE:
            begin
                ob_next = ~blue_reg;
                og_next = ~green_reg;
                or_next = ~red_reg;
            end
            MODE_THRESHOLD:
            begin
                ob_next     = (avg_reg < threshold_reg) ? '0 : '1;
                single_next = 1'b1;
            end
            default: ;  // unused codes pass the pixel through
        endcase
        // one-channel results carry the gray value in blue only
        if (single_next)
        begin
            og_next = '0;
            or_next = '0;
        end
    end

    // result register
    logic [23:0] out_data_reg;
    logic        out_user_reg;

    always_ff @(posedge clk)
    begin
        if (out_advance && in_valid_reg)
        begin
            out_data_reg <= {or_next, og_next, ob_next};
            out_user_reg <= single_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // checks
    `PPOU_ASSERT_RST(a_reset_empty, !rst_n |=> !in_valid_reg && !out_valid_reg,
        "pipeline not empty during reset")
    `PPOU_ASSERT(a_no_overrun, in_load |-> !(in_valid_reg && !out_advance),
        "item accepted into a full, stalled stage")
    `PPOU_ASSERT(a_stage_moves, in_valid_reg && out_advance |=> out_valid_reg,
        "stage one item lost on its way to the result register")
    `PPOU_ASSERT(a_single_zero, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[23:8] == 16'd0,
        "one-channel result with nonzero green or red")
    `PPOU_ASSERT(a_thresh_binary,
        m_axis_tvalid && (mode_reg == MODE_THRESHOLD)
            |-> m_axis_tdata[7:0] == 8'd0 || m_axis_tdata[7:0] == 8'd255,
        "threshold result is neither black nor white")

endmodule

`default_nettype wire

>>> hw/rtl/ppou_lane.sv
// one color channel: pixel register and weight or contrast product register
`timescale 1ns / 1ps
`default_nettype none

module ppou_lane (
    input  wire logic                              clk,
    input  wire ppou_pkg::lane_ctrl_t              ctrl,
    input  wire logic [ppou_pkg::PIX_W-1:0]        pix,
    input  wire logic [ppou_pkg::WEIGHT_W-1:0]     weight,
    input  wire logic [ppou_pkg::GAIN_W-1:0]       gain,
    output logic      [ppou_pkg::PIX_W-1:0]        pix_reg,
    output logic signed [ppou_pkg::PROD_W-1:0]     prod_reg
);
    import ppou_pkg::*;

    logic signed [GAIN_W:0]     a_op;
    logic signed [PIX_W:0]      b_op;
    logic [PIX_W:0]             centered;
    logic signed [PROD_W-1:0]   prod_next;

    // weighted gray: pixel times weight; contrast: gain times (pixel - 128)
    always_comb
    begin
        centered = {1'b0, pix} - CONTRAST_MID;
        if (ctrl.weighted)
        begin
            a_op = $signed({{(GAIN_W + 1 - WEIGHT_W){1'b0}}, weight});
            b_op = $signed({1'b0, pix});
        end
        else
        begin
            a_op = $signed({1'b0, gain});
            b_op = $signed(centered);
        end
        prod_next = PROD_W'(a_op) * PROD_W'(b_op);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            pix_reg  <= pix;
            prod_reg <= prod_next;
        end
    end

endmodule

`default_nettype wire

>>> tb/ppou_result_checker.sv
// checker for the pixel point operation unit: predicts each result item and compares
`timescale 1ns / 1ps

module ppou_result_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [23:0]                   s_tdata,     // pix_blue, pix_green, pix_red
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [23:0]                   m_tdata,     // out_blue, out_green, out_red
    input  logic                          m_tuser,     // single_channel
    input  logic                          cfg_we,
    input  logic [ppou_pkg::INDEX_W-1:0]  cfg_index,
    input  logic [ppou_pkg::CFG_W-1:0]    cfg_data,
    output int                            mismatches,
    output int                            pending,
    output int                            results_checked
);
    import ppou_pkg::*;

    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
        logic             single;
    } pixel_result_t;

    // shadow copy of the configuration registers
    logic [3:0]          mode_q;
    logic [WEIGHT_W-1:0] red_w_q;
    logic [WEIGHT_W-1:0] green_w_q;
    logic [WEIGHT_W-1:0] blue_w_q;
    logic [2:0]          quant_q;
    logic [OFFS_W-1:0]   offset_q;
    logic [GAIN_W-1:0]   gain_q;
    logic [PIX_W-1:0]    thresh_q;

    pixel_result_t expected_pixels[$];

    initial
    begin
        mismatches      = 0;
        pending         = 0;
        results_checked = 0;
    end

    function automatic logic [PIX_W-1:0] clamp_byte(input int v);
        if (v < 0)
            return '0;
        if (v > 255)
            return '1;
        return v[PIX_W-1:0];
    endfunction

    function automatic pixel_result_t point_op_result(input logic [23:0] pix);
        pixel_result_t res;
        int b, g, r, avg, w, n, step, off, prod;
        b   = int'(pix[7:0]);
        g   = int'(pix[15:8]);
        r   = int'(pix[23:16]);
        avg = (r + g + b) / 3;
        res = '{pix[7:0], pix[15:8], pix[23:16], 1'b0};
        case (mode_q)
            MODE_BLUE:
            begin
                res.green = '0;
                res.red   = '0;
            end
            MODE_GREEN:
            begin
                res.blue = '0;
                res.red  = '0;
            end
            MODE_RED:
            begin
                res.blue  = '0;
                res.green = '0;
            end
            MODE_AVG_GRAY:
            begin
                res.blue   = PIX_W'(avg);
                res.single = 1'b1;
            end
            MODE_WGT_GRAY:
            begin
                w = (r * int'(red_w_q) + g * int'(green_w_q) + b * int'(blue_w_q)) >> 8;
                res.blue   = clamp_byte(w);
                res.single = 1'b1;
            end
            MODE_QUANTIZE:
            begin
                // levels code 0 acts as 2 levels, 5..7 as 16 levels
                n = (quant_q < 1) ? 1 : (quant_q > 4) ? 4 : int'(quant_q);
                step = 255 / ((1 << n) - 1);
                res.blue   = PIX_W'((avg >> (8 - n)) * step);
                res.single = 1'b1;
            end
            MODE_BRIGHTNESS:
            begin
                off = int'($signed(offset_q));
                res.blue  = clamp_byte(b + off);
                res.green = clamp_byte(g + off);
                res.red   = clamp_byte(r + off);
            end
            MODE_CONTRAST:
            begin
                // arithmetic shift gives the floor of the quotient
                prod = int'(gain_q) * (b - 128);
                res.blue  = clamp_byte((prod >>> 8) + 128);
                prod = int'(gain_q) * (g - 128);
                res.green = clamp_byte((prod >>> 8) + 128);
                prod = int'(gain_q) * (r - 128);
                res.red   = clamp_byte((prod >>> 8) + 128);
            end
            MODE_NEGATIVE:
            begin
                res.blue  = ~pix[7:0];
                res.green = ~pix[15:8];
                res.red   = ~pix[23:16];
            end
            MODE_THRESHOLD:
            begin
                res.blue   = (avg < int'(thresh_q)) ? '0 : '1;
                res.single = 1'b1;
            end
            default: ;  // unused codes pass the pixel through
        endcase
        if (res.single)
        begin
            res.green = '0;
            res.red   = '0;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("mismatch, %s at result %0d: got 0x%0h, expected 0x%0h",
                 what, results_checked, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pixel_result_t want, got;
        if (!rst_n)
        begin
            mode_q    <= MODE_COPY;
            red_w_q   <= 9'd77;
            green_w_q <= 9'd150;
            blue_w_q  <= 9'd29;
            quant_q   <= 3'd4;
            offset_q  <= 9'd33;
            gain_q    <= 12'd128;
            thresh_q  <= 8'd100;
            expected_pixels.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = '{m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tuser};
                if (expected_pixels.size() == 0)
                    report_mismatch("result with no item pending", int'(got), 0);
                else
                begin
                    want = expected_pixels.pop_front();
                    if (got.blue !== want.blue)
                        report_mismatch("out_blue", got.blue, want.blue);
                    if (got.green !== want.green)
                        report_mismatch("out_green", got.green, want.green);
                    if (got.red !== want.red)
                        report_mismatch("out_red", got.red, want.red);
                    if (got.single !== want.single)
                        report_mismatch("single_channel", got.single, want.single);
                end
                results_checked++;
            end
            // prediction uses the settings in force before this edge
            if (s_tvalid && s_tready)
                expected_pixels.push_back(point_op_result(s_tdata));
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MODE:         mode_q    <= cfg_data[3:0];
                    REG_RED_WEIGHT:   red_w_q   <= cfg_data[WEIGHT_W-1:0];
                    REG_GREEN_WEIGHT: green_w_q <= cfg_data[WEIGHT_W-1:0];
                    REG_BLUE_WEIGHT:  blue_w_q  <= cfg_data[WEIGHT_W-1:0];
                    REG_QUANT_LOG2:   quant_q   <= cfg_data[2:0];
                    REG_BRIGHT_OFFS:  offset_q  <= cfg_data[OFFS_W-1:0];
                    REG_CONTR_GAIN:   gain_q    <= cfg_data[GAIN_W-1:0];
                    REG_THRESHOLD:    thresh_q  <= cfg_data[PIX_W-1:0];
                    default: ;
                endcase
            end
        end
        pending = expected_pixels.size();
    end

endmodule

>>> tb/tb_pixel_point_operation_unit_core.sv
// testbench top for the pixel point operation unit: stimulus, config phases and verdict
`timescale 1ns / 1ps

module tb_pixel_point_operation_unit_core;
    import ppou_pkg::*;

    // run stops here no matter what; far above the slowest legal run
    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_ITEMS  = 2000;
    localparam int HOLD_CYCLES   = 200;
    // block holds each item in a stage one and a stage two register, leave a little margin
    localparam int SETTLE_CYCLES = 4;

    logic               clk;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [23:0]        s_axis_tdata;   // pix_blue, pix_green, pix_red
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [23:0]        m_axis_tdata;   // out_blue, out_green, out_red
    logic               m_axis_tuser;   // single_channel
    logic               cfg_we;
    logic [INDEX_W-1:0] cfg_index;
    logic [CFG_W-1:0]   cfg_data;

    int mismatches;
    int pending;
    int results_checked;

    // run state of the stimulus, the result sink and the watchdog
    bit tx_calm;
    bit rx_calm;
    int rx_hold_request;
    int holds_done;
    int items_sent;
    int phases_run;
    int cycle_count;

    pixel_point_operation_unit_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    ppou_result_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_axis_tvalid),
        .s_tready        (s_axis_tready),
        .s_tdata         (s_axis_tdata),
        .m_tvalid        (m_axis_tvalid),
        .m_tready        (m_axis_tready),
        .m_tdata         (m_axis_tdata),
        .m_tuser         (m_axis_tuser),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .pending         (pending),
        .results_checked (results_checked)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still pending", cycle_count, pending);
            $display("TB_ERROR");
            $finish;
        end
    end

    // width of each config register, bits above it are don't care
    function automatic int reg_width(input logic [INDEX_W-1:0] idx);
        case (idx)
            REG_MODE:       return 4;
            REG_QUANT_LOG2: return 3;
            REG_THRESHOLD:  return 8;
            REG_CONTR_GAIN: return 12;
            default:        return 9;   // weights and brightness offset
        endcase
    endfunction

    // config value for a random phase: extremes often, otherwise anything
    function automatic int pick_reg_value(input logic [INDEX_W-1:0] idx);
        int w;
        w = reg_width(idx);
        if (idx == REG_MODE)
            // mostly defined modes, sometimes the unused codes
            return ($urandom_range(0, 7) == 0) ? $urandom_range(MODE_THRESHOLD + 1, 15)
                                               : $urandom_range(MODE_COPY, MODE_THRESHOLD);
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return (1 << w) - 1;
            default: return $urandom_range(0, (1 << w) - 1);
        endcase
    endfunction

    function automatic logic [7:0] random_channel();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'd128;
            3:       return 8'd127;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] random_pixel();
        return {random_channel(), random_channel(), random_channel()};
    endfunction

    // called at a falling edge, returns at a falling edge; upper data bits are noise
    task automatic write_reg(input logic [INDEX_W-1:0] idx, input int value);
        int w;
        w = reg_width(idx);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(($urandom << w) | (value & ((1 << w) - 1)));
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // offer one item, after a random idle gap unless tx_calm, hold it until accepted
    task automatic send_pixel(input logic [23:0] pix);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // stop offering and wait until every expected result has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_and_send(input logic [INDEX_W-1:0] idx, input int value,
                                input logic [23:0] pix);
        drain();
        write_reg(idx, value);
        send_pixel(pix);
    endtask

    // result sink: random back-pressure, calm stretches, and one long hold on request
    initial
    begin : result_sink
        int gap;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold_request > 0)
            begin
                gap = rx_hold_request;
                rx_hold_request = 0;
                holds_done++;
            end
            else if (rx_calm)
                gap = 0;
            else
                gap = $urandom_range(0, 12);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    initial
    begin : stimulus
        int phase_len;
        int target;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        m_axis_tready   = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = REG_MODE;
        cfg_data        = '0;
        tx_calm         = 1'b0;
        rx_calm         = 1'b0;
        rx_hold_request = 0;
        holds_done      = 0;
        items_sent      = 0;
        phases_run      = 0;
        cycle_count     = 0;
        rst_n           = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // ---- directed part ----
        // reset settings, copy mode, all-zero and all-one pixels
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);
        // every mode code with the reset settings, unused codes included
        for (int m = MODE_BLUE; m <= 15; m++)
            set_and_send(REG_MODE, m, {8'(m * 16 + 15), 8'(255 - m * 9), 8'(m * 3 + 1)});

        // weights summing past 256: weighted gray saturates
        drain();
        write_reg(REG_RED_WEIGHT, 256);
        write_reg(REG_GREEN_WEIGHT, 256);
        write_reg(REG_BLUE_WEIGHT, 256);
        set_and_send(REG_MODE, MODE_WGT_GRAY, 24'hFFFFFF);

        // quantize with level codes out of range on both sides
        drain();
        write_reg(REG_QUANT_LOG2, 0);
        set_and_send(REG_MODE, MODE_QUANTIZE, 24'hC0A0F0);
        set_and_send(REG_QUANT_LOG2, 5, 24'h7F8081);

        // brightness: an offset of -255 clamps low
        drain();
        write_reg(REG_BRIGHT_OFFS, -255);
        set_and_send(REG_MODE, MODE_BRIGHTNESS, 24'h10FF00);

        // contrast at the largest gain and at zero gain
        drain();
        write_reg(REG_CONTR_GAIN, 4095);
        set_and_send(REG_MODE, MODE_CONTRAST, 24'h80FF00);
        set_and_send(REG_CONTR_GAIN, 0, 24'h00FF7F);

        // threshold boundaries: average equal to the level gives white
        drain();
        write_reg(REG_THRESHOLD, 255);
        set_and_send(REG_MODE, MODE_THRESHOLD, 24'hFFFFFF);
        set_and_send(REG_THRESHOLD, 0, 24'h000000);

        // ---- random phases, fresh settings each time ----
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
        begin
            drain();
            for (int r = REG_MODE; r <= REG_THRESHOLD; r++)
                write_reg(r[INDEX_W-1:0], pick_reg_value(r[INDEX_W-1:0]));
            phase_len = $urandom_range(40, 120);
            if (phases_run == 1)
            begin
                // long hold on the result side while items keep coming, fills the pipe
                tx_calm         = 1'b1;
                rx_calm         = 1'b0;
                rx_hold_request = HOLD_CYCLES;
            end
            else
            begin
                tx_calm = ($urandom_range(0, 3) == 0);
                rx_calm = ($urandom_range(0, 3) == 0);
            end
            repeat (phase_len)
                send_pixel(random_pixel());
            phases_run++;
        end

        // ---- wrap up ----
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("covered all mode codes, register extremes and %0d random config phases",
                 phases_run);
        $display("%0d items sent, %0d results checked, %0d long result holds",
                 items_sent, results_checked, holds_done);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
